FILE: hdl/tsbm_pkg.sv
// Shared types and constants of the typed slot buffer manager.
package tsbm_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int IDX_IN_W = 3;
  localparam int CMP_W = (SLOT_W > IDX_IN_W) ? SLOT_W : IDX_IN_W;

  typedef enum logic [1:0] {
    REQ_CLAIM_FREE = 2'd0,
    REQ_COMMIT     = 2'd1,
    REQ_CLAIM_KIND = 2'd2,
    REQ_RELEASE    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    SLOT_FREE     = 2'd0,
    SLOT_RESERVED = 2'd1,
    SLOT_FULL     = 2'd2
  } slot_state_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_NO_KIND      = 2'd2,
    ST_NOT_RESERVED = 2'd3
  } status_t;

  // A request travelling along the row of slot cells.
  typedef struct packed {
    logic                vld;
    req_t                req;
    logic                kind;
    logic [IDX_IN_W-1:0] slot_index;
    logic                hit;
    logic [SLOT_W-1:0]   granted;
  } probe_t;

endpackage

FILE: hdl/typed_slot_buffer_manager_core.sv
// Top level of the typed slot buffer manager: request entry, slot cell row and result tally.
//
// Requests enter on in_valid/in_stall with req_type, item_kind and slot_index;
// a transaction completes at a clock edge where in_valid is high and in_stall low.
// Each request yields exactly one result on out_valid/out_stall carrying
// granted_slot, status and the free, jacket and shoe counts after the request.
// The request travels down a row of SLOT_COUNT slot cells, one cell per cycle;
// the first matching cell serves it, so the walk sets the timing.
// The result passes through the slot cell registers, the holding register and the
// output register, and one request is in the block at a time, so a new request is
// taken only once the last result has moved to the output register.
// A finished result waits in a holding register while the output register is
// stalled; in_stall stays high until the result has moved to the output register.
// Synchronous reset frees every slot, sets the free count to SLOT_COUNT, clears
// the jacket and shoe counts and drops all pending work.
module typed_slot_buffer_manager_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic       item_kind,
  input  logic [2:0] slot_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] granted_slot,
  output logic [1:0] status,
  output logic [3:0] free_slots,
  output logic [3:0] jackets_ready,
  output logic [3:0] shoes_ready
);

  tsbm_pkg::probe_t probe [tsbm_pkg::SLOT_COUNT+1];
  tsbm_pkg::probe_t tail;

  logic busy;
  logic busy_next;
  logic accept;
  logic move_out;

  logic [tsbm_pkg::CNT_W-1:0] free_total;
  logic [tsbm_pkg::CNT_W-1:0] free_total_next;
  logic [tsbm_pkg::CNT_W-1:0] jacket_total;
  logic [tsbm_pkg::CNT_W-1:0] jacket_total_next;
  logic [tsbm_pkg::CNT_W-1:0] shoe_total;
  logic [tsbm_pkg::CNT_W-1:0] shoe_total_next;
  tsbm_pkg::status_t          result_status;

  logic                        pend_valid;
  logic [tsbm_pkg::SLOT_W-1:0] pend_granted;
  tsbm_pkg::status_t           pend_status;

  assign accept = in_valid && !busy;
  assign in_stall = busy;
  assign move_out = pend_valid && (!out_valid || !out_stall);

  always_comb begin
    probe[0].vld = accept;
    probe[0].req = tsbm_pkg::req_t'(req_type);
    probe[0].kind = item_kind;
    probe[0].slot_index = slot_index;
    probe[0].hit = 1'b0;
    probe[0].granted = '0;
  end

  for (genvar i = 0; i < tsbm_pkg::SLOT_COUNT; i++) begin : g_cell
    tsbm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (tsbm_pkg::SLOT_W'(i)),
      .probe_in   (probe[i]),
      .probe_out  (probe[i+1])
    );
  end

  assign tail = probe[tsbm_pkg::SLOT_COUNT];

  always_comb begin
    free_total_next = free_total;
    jacket_total_next = jacket_total;
    shoe_total_next = shoe_total;
    result_status = tsbm_pkg::ST_OK;
    unique case (tail.req)
      tsbm_pkg::REQ_CLAIM_FREE: begin
        if (!tail.hit) begin
          result_status = tsbm_pkg::ST_NO_FREE;
        end else if (free_total != '0) begin
          free_total_next = free_total - 1'b1;
        end
      end
      tsbm_pkg::REQ_COMMIT: begin
        if (!tail.hit) begin
          result_status = tsbm_pkg::ST_NOT_RESERVED;
        end else if (tail.kind) begin
          shoe_total_next = shoe_total + 1'b1;
        end else begin
          jacket_total_next = jacket_total + 1'b1;
        end
      end
      tsbm_pkg::REQ_CLAIM_KIND: begin
        if (!tail.hit) begin
          result_status = tsbm_pkg::ST_NO_KIND;
        end else if (tail.kind) begin
          if (shoe_total != '0) begin
            shoe_total_next = shoe_total - 1'b1;
          end
        end else if (jacket_total != '0) begin
          jacket_total_next = jacket_total - 1'b1;
        end
      end
      tsbm_pkg::REQ_RELEASE: begin
        if (!tail.hit) begin
          result_status = tsbm_pkg::ST_NOT_RESERVED;
        end else begin
          free_total_next = free_total + 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    busy_next = busy;
    if (accept) begin
      busy_next = 1'b1;
    end else if (move_out) begin
      busy_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
      free_total <= tsbm_pkg::CNT_W'(tsbm_pkg::SLOT_COUNT);
      jacket_total <= '0;
      shoe_total <= '0;
    end else begin
      busy <= busy_next;
      if (tail.vld) begin
        pend_valid <= 1'b1;
        free_total <= free_total_next;
        jacket_total <= jacket_total_next;
        shoe_total <= shoe_total_next;
      end else if (move_out) begin
        pend_valid <= 1'b0;
      end
      if (move_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.vld) begin
      pend_granted <= tail.hit ? tail.granted : '0;
      pend_status <= result_status;
    end
    if (move_out) begin
      granted_slot <= 3'(pend_granted);
      status <= pend_status;
      free_slots <= 4'(free_total);
      jackets_ready <= 4'(jacket_total);
      shoes_ready <= 4'(shoe_total);
    end
  end

endmodule

FILE: hdl/tsbm_cell.sv
// One slot cell: holds a slot's state and kind and serves a passing request.
module tsbm_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [tsbm_pkg::SLOT_W-1:0] cell_index,
  input  tsbm_pkg::probe_t           probe_in,
  output tsbm_pkg::probe_t           probe_out
);

  tsbm_pkg::slot_state_t state;
  tsbm_pkg::slot_state_t state_next;
  logic                  kind;
  logic                  kind_next;
  tsbm_pkg::probe_t      probe_next;
  logic                  addressed;
  logic                  take;

  always_comb begin
    addressed = (tsbm_pkg::CMP_W'(probe_in.slot_index) == tsbm_pkg::CMP_W'(cell_index)) &&
                (state == tsbm_pkg::SLOT_RESERVED);
    take = 1'b0;
    state_next = state;
    kind_next = kind;
    probe_next = probe_in;
    if (probe_in.vld && !probe_in.hit) begin
      unique case (probe_in.req)
        tsbm_pkg::REQ_CLAIM_FREE: begin
          if (state == tsbm_pkg::SLOT_FREE) begin
            take = 1'b1;
            state_next = tsbm_pkg::SLOT_RESERVED;
            probe_next.granted = cell_index;
          end
        end
        tsbm_pkg::REQ_COMMIT: begin
          if (addressed) begin
            take = 1'b1;
            state_next = tsbm_pkg::SLOT_FULL;
            kind_next = probe_in.kind;
          end
        end
        tsbm_pkg::REQ_CLAIM_KIND: begin
          if (state == tsbm_pkg::SLOT_FULL && kind == probe_in.kind) begin
            take = 1'b1;
            state_next = tsbm_pkg::SLOT_RESERVED;
            probe_next.granted = cell_index;
          end
        end
        tsbm_pkg::REQ_RELEASE: begin
          if (addressed) begin
            take = 1'b1;
            state_next = tsbm_pkg::SLOT_FREE;
          end
        end
      endcase
    end
    if (take) begin
      probe_next.hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsbm_pkg::SLOT_FREE;
      probe_out <= '0;
    end else begin
      state <= state_next;
      probe_out <= probe_next;
    end
  end

  always_ff @(posedge clk) begin
    kind <= kind_next;
  end

endmodule

FILE: dv/tb_typed_slot_buffer_manager_core.sv
// Self-checking testbench for the typed slot buffer manager core with a slot ledger scoreboard.
module tb_typed_slot_buffer_manager_core;

  localparam logic KIND_JACKET = 1'b0;
  localparam logic KIND_SHOES = 1'b1;
  localparam int PHASE_ITEMS = 432;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [2:0]        granted;
    tsbm_pkg::status_t status;
    logic [3:0]        free_cnt;
    logic [3:0]        jacket_cnt;
    logic [3:0]        shoe_cnt;
  } slot_answer_t;

  class slot_ledger;
    tsbm_pkg::slot_state_t state_of[tsbm_pkg::SLOT_COUNT];
    logic                  kind_of[tsbm_pkg::SLOT_COUNT];
    logic [3:0]            free_cnt;
    logic [3:0]            jacket_cnt;
    logic [3:0]            shoe_cnt;
    slot_answer_t          owed[$];
    int                    errors;

    function new();
      foreach (state_of[i]) begin
        state_of[i] = tsbm_pkg::SLOT_FREE;
        kind_of[i] = KIND_JACKET;
      end
      free_cnt = 4'(tsbm_pkg::SLOT_COUNT);
      jacket_cnt = '0;
      shoe_cnt = '0;
      errors = 0;
    endfunction

    function int lowest(tsbm_pkg::slot_state_t want, logic k);
      for (int i = 0; i < tsbm_pkg::SLOT_COUNT; i++) begin
        if (state_of[i] == want && (want != tsbm_pkg::SLOT_FULL || kind_of[i] == k)) return i;
      end
      return -1;
    endfunction

    function int pick_reserved();
      int held[$];
      foreach (state_of[i]) begin
        if (state_of[i] == tsbm_pkg::SLOT_RESERVED) held.push_back(i);
      end
      if (held.size() == 0) return -1;
      return held[$urandom_range(0, held.size() - 1)];
    endfunction

    function void take_request(tsbm_pkg::req_t r, logic k, logic [2:0] idx);
      slot_answer_t a;
      int s;
      a = '0;
      a.status = tsbm_pkg::ST_OK;
      case (r)
        tsbm_pkg::REQ_CLAIM_FREE: begin
          s = lowest(tsbm_pkg::SLOT_FREE, KIND_JACKET);
          if (s < 0) begin
            a.status = tsbm_pkg::ST_NO_FREE;
          end else begin
            state_of[s] = tsbm_pkg::SLOT_RESERVED;
            if (free_cnt > 0) free_cnt--;
            a.granted = 3'(s);
          end
        end
        tsbm_pkg::REQ_COMMIT: begin
          if (idx >= tsbm_pkg::SLOT_COUNT || state_of[idx] != tsbm_pkg::SLOT_RESERVED) begin
            a.status = tsbm_pkg::ST_NOT_RESERVED;
          end else begin
            state_of[idx] = tsbm_pkg::SLOT_FULL;
            kind_of[idx] = k;
            if (k == KIND_SHOES) shoe_cnt++;
            else jacket_cnt++;
          end
        end
        tsbm_pkg::REQ_CLAIM_KIND: begin
          s = lowest(tsbm_pkg::SLOT_FULL, k);
          if (s < 0) begin
            a.status = tsbm_pkg::ST_NO_KIND;
          end else begin
            state_of[s] = tsbm_pkg::SLOT_RESERVED;
            if (k == KIND_SHOES) begin
              if (shoe_cnt > 0) shoe_cnt--;
            end else begin
              if (jacket_cnt > 0) jacket_cnt--;
            end
            a.granted = 3'(s);
          end
        end
        default: begin
          if (idx >= tsbm_pkg::SLOT_COUNT || state_of[idx] != tsbm_pkg::SLOT_RESERVED) begin
            a.status = tsbm_pkg::ST_NOT_RESERVED;
          end else begin
            state_of[idx] = tsbm_pkg::SLOT_FREE;
            free_cnt++;
          end
        end
      endcase
      a.free_cnt = free_cnt;
      a.jacket_cnt = jacket_cnt;
      a.shoe_cnt = shoe_cnt;
      owed.push_back(a);
    endfunction

    function void match_result(slot_answer_t got);
      slot_answer_t exp;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: result with none outstanding: slot %0d status %0d free %0d jk %0d sh %0d",
                 $time, got.granted, got.status, got.free_cnt, got.jacket_cnt, got.shoe_cnt);
        return;
      end
      exp = owed.pop_front();
      if (got !== exp) begin
        errors++;
        $display("%0t: mismatch expected slot %0d status %0d free %0d jk %0d sh %0d, %s",
                 $time, exp.granted, exp.status, exp.free_cnt, exp.jacket_cnt, exp.shoe_cnt,
                 $sformatf("actual slot %0d status %0d free %0d jk %0d sh %0d",
                           got.granted, got.status, got.free_cnt, got.jacket_cnt,
                           got.shoe_cnt));
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] req_type = '0;
  logic       item_kind = 1'b0;
  logic [2:0] slot_index = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] granted_slot;
  logic [1:0] status;
  logic [3:0] free_slots;
  logic [3:0] jackets_ready;
  logic [3:0] shoes_ready;

  int         idle_pct = 0;
  int         stall_pct = 0;
  int         cycle_cnt = 0;
  slot_ledger ledger = new();

  typed_slot_buffer_manager_core u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .item_kind(item_kind),
    .slot_index(slot_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .granted_slot(granted_slot),
    .status(status),
    .free_slots(free_slots),
    .jackets_ready(jackets_ready),
    .shoes_ready(shoes_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      ledger.match_result({granted_slot, tsbm_pkg::status_t'(status), free_slots,
                           jackets_ready, shoes_ready});
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_typed_slot_buffer_manager_core: done, errors");
      $finish;
    end
  end

  task automatic send_req(tsbm_pkg::req_t r, logic k, logic [2:0] idx);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r;
    item_kind <= k;
    slot_index <= idx;
    do @(posedge clk); while (in_stall);
    ledger.take_request(r, k, idx);
  endtask

  task automatic random_request();
    int roll;
    int pick;
    tsbm_pkg::req_t r;
    logic k;
    logic [2:0] idx;
    roll = $urandom_range(0, 99);
    k = 1'($urandom_range(0, 1));
    idx = 3'($urandom_range(0, 7));
    if (roll < 30) r = tsbm_pkg::REQ_CLAIM_FREE;
    else if (roll < 60) r = tsbm_pkg::REQ_COMMIT;
    else if (roll < 80) r = tsbm_pkg::REQ_CLAIM_KIND;
    else if (roll < 95) r = tsbm_pkg::REQ_RELEASE;
    else r = tsbm_pkg::req_t'($urandom_range(0, 3));
    if (roll < 95 && (r == tsbm_pkg::REQ_COMMIT || r == tsbm_pkg::REQ_RELEASE)) begin
      pick = ledger.pick_reserved();
      if (pick >= 0 && $urandom_range(0, 9) != 0) idx = 3'(pick);
    end
    send_req(r, k, idx);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_req(tsbm_pkg::REQ_CLAIM_KIND, KIND_JACKET, 3'd0);
    send_req(tsbm_pkg::REQ_RELEASE, KIND_SHOES, 3'd7);
    repeat (tsbm_pkg::SLOT_COUNT) send_req(tsbm_pkg::REQ_CLAIM_FREE, KIND_JACKET, 3'd0);
    send_req(tsbm_pkg::REQ_CLAIM_FREE, KIND_SHOES, 3'd7);
    send_req(tsbm_pkg::REQ_COMMIT, KIND_JACKET, 3'd0);
    send_req(tsbm_pkg::REQ_COMMIT, KIND_SHOES, 3'd7);
    send_req(tsbm_pkg::REQ_COMMIT, KIND_SHOES, 3'd0);
    send_req(tsbm_pkg::REQ_CLAIM_KIND, KIND_SHOES, 3'd0);
    // The shoe slot is now held by a consumer, so committing it again is served.
    send_req(tsbm_pkg::REQ_COMMIT, KIND_JACKET, 3'd7);
    send_req(tsbm_pkg::REQ_CLAIM_KIND, KIND_SHOES, 3'd0);
    send_req(tsbm_pkg::REQ_CLAIM_KIND, KIND_JACKET, 3'd0);
    send_req(tsbm_pkg::REQ_RELEASE, KIND_JACKET, 3'd0);
    send_req(tsbm_pkg::REQ_RELEASE, KIND_JACKET, 3'd3);
    send_req(tsbm_pkg::REQ_COMMIT, KIND_SHOES, 3'd5);
    send_req(tsbm_pkg::REQ_COMMIT, KIND_SHOES, 3'd3);
    send_req(tsbm_pkg::REQ_RELEASE, KIND_JACKET, 3'd7);
    send_req(tsbm_pkg::REQ_CLAIM_KIND, KIND_JACKET, 3'd0);
    send_req(tsbm_pkg::REQ_RELEASE, KIND_SHOES, 3'd7);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 63; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 63; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      repeat (PHASE_ITEMS) random_request();
    end
    in_valid <= 1'b0;

    while (ledger.owed.size() != 0) @(posedge clk);
    repeat (4 * (tsbm_pkg::SLOT_COUNT + 2)) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("tb_typed_slot_buffer_manager_core: done, clean");
    end else begin
      $display("tb_typed_slot_buffer_manager_core: done, errors");
    end
    $finish;
  end

endmodule
